[rtl/fkrts_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the fixed-key reverse table search.
// No dependencies; the front end, the back end and the top level refer to this package by scoped names.

package fkrts_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_LOWER   = 3'd3,
    OP_UPPER   = 3'd4,
    OP_BYTE    = 3'd5,
    OP_REVERSE = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_FULL  = 3'd1,
    ERR_EMPTY = 3'd2,
    ERR_RANGE = 3'd3,
    ERR_POS   = 3'd4
  } err_e;

  // Work the back end still has to do for one command.
  typedef enum logic [2:0] {
    K_DONE,
    K_PUSH,
    K_LOWER,
    K_UPPER,
    K_BYTE,
    K_REVERSE
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_REVERSE
  } bk_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] found;
    logic [IDX_W-1:0] count;
    err_e             err;
  } res_t;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [POS_W-1:0]  byte_sel;
    logic [BYTE_W-1:0] byte_val;
    res_t              res;
  } cmd_t;

  // A length of zero behaves as one byte, anything above eight as eight.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    if (raw == '0) begin
      n = LEN_W'(1);
    end else if (raw > LEN_W'(8)) begin
      n = LEN_W'(8);
    end else begin
      n = raw;
    end
    return n;
  endfunction

  function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (LEN_W'(k) < n) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Reverses the order of the low n bytes; bytes above the key length come out zero.
  function automatic logic [KEY_W-1:0] flip_bytes(input logic [KEY_W-1:0] v,
                                                  input logic [LEN_W-1:0] n);
    logic [KEY_W-1:0] r;
    logic [LEN_W-1:0] src;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      src = n - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < n) begin
        r[8*k +: 8] = v[{src[2:0], 3'b000} +: 8];
      end
    end
    return r;
  endfunction

endpackage

[rtl/fkrts_fifo.sv]
`timescale 1ns / 1ps
// Small register queue used between the front end, the back end and the result port.
// Depends on nothing but its parameters.

module fkrts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [Width-1:0] storage_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             wr_en, rd_en;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign wr_en   = wr_i & ~full_o;
  assign rd_en   = rd_i & ~empty_o;
  assign rdata_o = storage_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      storage_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/fkrts_front.sv]
`timescale 1ns / 1ps
// Front end: accepts words, keeps the entry count and resolves every error and trivial case.
// Depends on fkrts_pkg; feeds the command queue that the back end drains.

module fkrts_front #(
  parameter int unsigned TableDepth = 1024,
  localparam int unsigned CntW      = $clog2(TableDepth + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  logic [fkrts_pkg::LEN_W-1:0]    key_len_i,
  input  logic [2:0]                     op_i,
  input  logic [fkrts_pkg::KEY_W-1:0]    key_value_i,
  input  logic [fkrts_pkg::IDX_W-1:0]    range_low_i,
  input  logic [fkrts_pkg::IDX_W-1:0]    range_high_i,
  input  logic [fkrts_pkg::POS_W-1:0]    byte_position_i,
  input  logic [fkrts_pkg::BYTE_W-1:0]   byte_value_i,
  output logic                           cmd_we_o,
  output fkrts_pkg::cmd_t                cmd_o,
  output logic [CntW-1:0]                cmd_cnt_o
);

  localparam int unsigned IdxW = fkrts_pkg::IDX_W;
  localparam int unsigned LenW = fkrts_pkg::LEN_W;
  localparam int unsigned CmpW = (CntW > IdxW) ? CntW : IdxW;

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] lo_w, hi_w, cnt_w;
  logic [LenW-1:0] pos_w;
  logic            accept;

  assign accept    = push_i & ~full_i;
  assign cmd_we_o  = accept;
  assign cmd_cnt_o = count_q;

  always_comb begin
    lo_w  = CmpW'(range_low_i);
    hi_w  = CmpW'(range_high_i);
    cnt_w = CmpW'(count_q);
    pos_w = LenW'(byte_position_i);

    count_d          = count_q;
    cmd_o.kind       = fkrts_pkg::K_DONE;
    cmd_o.key        = key_value_i & fkrts_pkg::len_mask(key_len_i);
    cmd_o.lo         = range_low_i;
    cmd_o.hi         = range_high_i;
    cmd_o.byte_sel   = fkrts_pkg::POS_W'(key_len_i - pos_w - LenW'(1));
    cmd_o.byte_val   = byte_value_i;
    cmd_o.res.found  = '0;
    cmd_o.res.err    = fkrts_pkg::ERR_OK;

    unique case (op_i)
      fkrts_pkg::OP_PUSH: begin
        if (count_q == CntW'(TableDepth)) begin
          cmd_o.res.err = fkrts_pkg::ERR_FULL;
        end else begin
          count_d    = count_q + 1'b1;
          cmd_o.kind = fkrts_pkg::K_PUSH;
        end
      end
      fkrts_pkg::OP_POP: begin
        if (count_q == '0) begin
          cmd_o.res.err = fkrts_pkg::ERR_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      fkrts_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      fkrts_pkg::OP_LOWER, fkrts_pkg::OP_UPPER: begin
        if (lo_w > hi_w || hi_w > cnt_w) begin
          cmd_o.res.err = fkrts_pkg::ERR_RANGE;
        end else if (lo_w == hi_w) begin
          cmd_o.res.found = range_low_i;
        end else begin
          cmd_o.kind = (op_i == fkrts_pkg::OP_LOWER) ? fkrts_pkg::K_LOWER
                                                     : fkrts_pkg::K_UPPER;
        end
      end
      fkrts_pkg::OP_BYTE: begin
        if (lo_w >= hi_w || hi_w > cnt_w) begin
          cmd_o.res.err = fkrts_pkg::ERR_RANGE;
        end else if (pos_w >= key_len_i) begin
          cmd_o.res.err = fkrts_pkg::ERR_POS;
        end else begin
          cmd_o.kind = fkrts_pkg::K_BYTE;
        end
      end
      fkrts_pkg::OP_REVERSE: begin
        if (count_q != '0) begin
          cmd_o.kind = fkrts_pkg::K_REVERSE;
        end
      end
      default: begin
      end
    endcase

    cmd_o.res.count = IdxW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

endmodule

[rtl/fkrts_back.sv]
`timescale 1ns / 1ps
// Back end: owns the key memory and carries out pushes, bisection searches and the reverse sweep.
// Depends on fkrts_pkg; drains the command queue and writes the result queue.

module fkrts_back #(
  parameter int unsigned TableDepth = 1024,
  localparam int unsigned CntW      = $clog2(TableDepth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fkrts_pkg::LEN_W-1:0] key_len_i,
  input  logic                        cmd_empty_i,
  input  fkrts_pkg::cmd_t             cmd_i,
  input  logic [CntW-1:0]             cmd_cnt_i,
  output logic                        cmd_pop_o,
  input  logic                        res_full_i,
  output logic                        res_we_o,
  output fkrts_pkg::res_t             res_o
);

  localparam int unsigned IdxW  = fkrts_pkg::IDX_W;
  localparam int unsigned KeyW  = fkrts_pkg::KEY_W;
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CmpW  = (CntW > IdxW) ? CntW : IdxW;

  fkrts_pkg::bk_state_e state_q, state_d;
  fkrts_pkg::cmd_t      cmd_q, cmd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      lo_q, lo_d, hi_q, hi_d, lo_n, hi_n;
  logic [IdxW-1:0]      mid_q, mid_d;
  logic [IdxW:0]        mid_sum;
  logic [AddrW-1:0]     idx_q, idx_d;

  logic [KeyW-1:0]      key_store_q [TableDepth];
  logic [KeyW-1:0]      rdata_q;
  logic [KeyW-1:0]      entry;
  logic [7:0]           entry_byte;
  logic                 go_right;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [KeyW-1:0]      mem_wdata;

  // Logical index i lives in physical slot count-1-i.
  function automatic logic [AddrW-1:0] slot_of(input logic [CntW-1:0] cnt,
                                               input logic [IdxW-1:0] mid);
    logic [CmpW-1:0] s;
    s = CmpW'(cnt) - CmpW'(mid) - CmpW'(1);
    return s[AddrW-1:0];
  endfunction

  assign entry      = rdata_q & fkrts_pkg::len_mask(key_len_i);
  assign entry_byte = rdata_q[{cmd_q.byte_sel, 3'b000} +: 8];

  always_comb begin
    unique case (cmd_q.kind)
      fkrts_pkg::K_LOWER: go_right = (entry < cmd_q.key);
      fkrts_pkg::K_UPPER: go_right = (entry <= cmd_q.key);
      fkrts_pkg::K_BYTE:  go_right = (entry_byte <= cmd_q.byte_val);
      default:            go_right = 1'b0;
    endcase
    lo_n = go_right ? mid_q + 1'b1 : lo_q;
    hi_n = go_right ? hi_q : mid_q;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    mid_sum   = '0;
    cmd_pop_o = 1'b0;
    res_we_o  = 1'b0;
    res_o     = cmd_q.res;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = fkrts_pkg::flip_bytes(entry, key_len_i);
    mem_raddr = idx_q;

    unique case (state_q)
      fkrts_pkg::BK_IDLE: begin
        // The result slot is reserved here: only this unit writes the result queue.
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cnt_d     = cmd_cnt_i;
          unique case (cmd_i.kind)
            fkrts_pkg::K_PUSH: begin
              mem_we    = 1'b1;
              mem_waddr = cmd_cnt_i[AddrW-1:0];
              mem_wdata = cmd_i.key;
              res_we_o  = 1'b1;
              res_o     = cmd_i.res;
            end
            fkrts_pkg::K_LOWER, fkrts_pkg::K_UPPER, fkrts_pkg::K_BYTE: begin
              lo_d      = cmd_i.lo;
              hi_d      = cmd_i.hi;
              mid_sum   = {1'b0, cmd_i.lo} + {1'b0, cmd_i.hi};
              mid_d     = mid_sum[IdxW:1];
              mem_raddr = slot_of(cmd_cnt_i, mid_d);
              state_d   = fkrts_pkg::BK_SEARCH;
            end
            fkrts_pkg::K_REVERSE: begin
              idx_d     = '0;
              mem_raddr = '0;
              state_d   = fkrts_pkg::BK_REVERSE;
            end
            default: begin
              res_we_o = 1'b1;
              res_o    = cmd_i.res;
            end
          endcase
        end
      end
      fkrts_pkg::BK_SEARCH: begin
        // The read data in hand belongs to mid_q; one bisection step per cycle.
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n == hi_n) begin
          res_we_o       = 1'b1;
          res_o.found    = lo_n;
          state_d        = fkrts_pkg::BK_IDLE;
        end else begin
          mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
          mid_d     = mid_sum[IdxW:1];
          mem_raddr = slot_of(cnt_q, mid_d);
        end
      end
      fkrts_pkg::BK_REVERSE: begin
        // Write back slot idx_q while the next slot is being read.
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (CntW'(idx_q) + CntW'(1) == cnt_q) begin
          res_we_o = 1'b1;
          state_d  = fkrts_pkg::BK_IDLE;
        end else begin
          idx_d     = idx_q + 1'b1;
          mem_raddr = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = fkrts_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fkrts_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= key_store_q[mem_raddr];
  end

endmodule

[rtl/fixed_key_reverse_table_search.sv]
`timescale 1ns / 1ps
// Top level of the fixed-key reverse table search: key length register, queues and both ends.
// Depends on fkrts_pkg, fkrts_fifo, fkrts_front and fkrts_back.
//
// Usage:
//   Input words enter through push/full like the write side of a queue; a word is taken
//   at a clock edge with push high and full low. Results leave like the read side of a
//   queue: while empty is low the oldest result sits on the result ports, and pop takes it.
//   Every word yields exactly one result, in order.
//   The key length register is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
//   always high. Write it only while no word is in flight, and clear the table afterward.
//   Push, pop, clear, errors and empty ranges pass from the command queue through the
//   back end straight into the result queue. A search runs one bisection step per cycle,
//   set by the single read port of the key memory. Reversing the keys sweeps one memory
//   entry per cycle.
//   A two-word command queue sits between the front end and the back end, so the input
//   keeps accepting words while a search or a sweep is running or a result waits.
//   When the result side stalls, results collect in a two-word queue; once it is full
//   the back end holds and the command queue then fills and raises full.
//   Reset empties both queues and the table and sets the key length to eight bytes.
//   The key memory itself is not cleared; only entries below the count are ever read.

module fixed_key_reverse_table_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [2:0]                   op_i,
  input  logic [63:0]                  key_value_i,
  input  logic [10:0]                  range_low_i,
  input  logic [10:0]                  range_high_i,
  input  logic [2:0]                   byte_position_i,
  input  logic [7:0]                   byte_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [10:0]                  found_index_o,
  output logic [10:0]                  entry_count_o,
  output logic [2:0]                   error_code_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [3:0]                   cfg_data_i
);

  localparam int unsigned CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmdW   = $bits(fkrts_pkg::cmd_t) + CntW;
  localparam int unsigned ResW   = $bits(fkrts_pkg::res_t);
  localparam int unsigned QDepth = 2;

  logic [fkrts_pkg::LEN_W-1:0] key_bytes_q, key_len;

  fkrts_pkg::cmd_t  front_cmd, back_cmd;
  logic [CntW-1:0]  front_cnt, back_cnt;
  logic             front_we;
  logic [CmdW-1:0]  cmd_wdata, cmd_rdata;
  logic             cmd_empty, cmd_pop;

  fkrts_pkg::res_t  back_res, out_res;
  logic             res_we, res_full;
  logic [ResW-1:0]  res_rdata;

  assign cfg_ready_o = 1'b1;
  assign key_len     = fkrts_pkg::eff_len(key_bytes_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= fkrts_pkg::LEN_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_bytes_q <= cfg_data_i;
    end
  end

  fkrts_front #(
    .TableDepth(TABLE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .key_len_i      (key_len),
    .op_i           (op_i),
    .key_value_i    (key_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .byte_position_i(byte_position_i),
    .byte_value_i   (byte_value_i),
    .cmd_we_o       (front_we),
    .cmd_o          (front_cmd),
    .cmd_cnt_o      (front_cnt)
  );

  assign cmd_wdata = {front_cmd, front_cnt};
  assign back_cmd  = fkrts_pkg::cmd_t'(cmd_rdata[CmdW-1:CntW]);
  assign back_cnt  = cmd_rdata[CntW-1:0];

  fkrts_fifo #(
    .Width(CmdW),
    .Depth(QDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (front_we),
    .wdata_i(cmd_wdata),
    .full_o (full),
    .rd_i   (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  fkrts_back #(
    .TableDepth(TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_len_i  (key_len),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (back_cmd),
    .cmd_cnt_i  (back_cnt),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_we_o   (res_we),
    .res_o      (back_res)
  );

  fkrts_fifo #(
    .Width(ResW),
    .Depth(QDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_we),
    .wdata_i(back_res),
    .full_o (res_full),
    .rd_i   (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign out_res       = fkrts_pkg::res_t'(res_rdata);
  assign found_index_o = out_res.found;
  assign entry_count_o = out_res.count;
  assign error_code_o  = out_res.err;

  // A flagged error never carries a search index.
  a_err_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o != fkrts_pkg::ERR_OK) |-> (found_index_o == '0))
    else $error("error result with nonzero found_index");

  // A search never points past the entries it was allowed to see.
  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && TABLE_DEPTH < 2048) |-> (found_index_o <= entry_count_o))
    else $error("found_index beyond entry_count");

  // The back end only writes a result when the result queue had room reserved for it.
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> !res_full)
    else $error("result written into a full result queue");

  // A command is only taken from the queue when it holds one.
  a_cmd_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

endmodule
